>>> rtl/core/rlsfs_pkg.sv
`timescale 1ns / 1ps

package rlsfs_pkg;

    // Default chain length and the upper bound that sizes the queue address field.
    localparam int LED_COUNT_DEF = 64;
    localparam int LED_COUNT_MAX = 1024;
    localparam int ADDR_W        = $clog2(LED_COUNT_MAX);

    // Frame layout: reset slots ahead of the data, then 24 data slots per LED.
    localparam int LEAD_RESET_SLOTS = 48;
    localparam int BITS_PER_LED     = 24;

    // Field widths.
    localparam int IDX_W   = 16;
    localparam int SLOT_W  = 11;
    localparam int CHAN_W  = 8;
    localparam int COLOR_W = 3 * CHAN_W;
    localparam int KEEP_W  = 9;
    localparam int POS_W   = 5;
    localparam int CODE_W  = 8;
    localparam int CFG_IDX_W = 2;

    // Full fade scale and the top bit of a color word.
    localparam int FADE_FULL = 256;
    localparam int TOP_BIT   = COLOR_W - 1;

    // Division by three of an 8-bit value: (x * 683) >> 11 is exact for x < 256.
    localparam int DIV3_RECIP = 683;
    localparam int DIV3_SHIFT = 11;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_SET_ONE = 2'd0,
        CMD_SET_ALL = 2'd1,
        CMD_FADE    = 2'd2,
        CMD_READ    = 2'd3
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DUTY_ONE   = 2'd0,
        REG_DUTY_ZERO  = 2'd1,
        REG_DUTY_RESET = 2'd2
    } reg_idx_t;

    // Configuration write as seen by the back end.
    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [CODE_W-1:0]    data;
    } cfg_wr_t;

    // One classified item on its way from front to back.
    typedef struct packed {
        cmd_t               op;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        logic [KEEP_W-1:0]  keep;
        logic               in_data;
        logic [POS_W-1:0]   bit_pos;
    } entry_t;

    // Front state machine.
    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_MOD,
        F_PUSH
    } front_state_t;

    // Back state machine.
    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_SET,
        B_FADE,
        B_READ
    } back_state_t;

endpackage

>>> rtl/core/rlsfs_front.sv
`timescale 1ns / 1ps

module rlsfs_front #(
    parameter int LED_COUNT = rlsfs_pkg::LED_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          cmd,
    input  logic [rlsfs_pkg::IDX_W-1:0]         led_index,
    input  logic [rlsfs_pkg::CHAN_W-1:0]        red,
    input  logic [rlsfs_pkg::CHAN_W-1:0]        green,
    input  logic [rlsfs_pkg::CHAN_W-1:0]        blue,
    input  logic [rlsfs_pkg::CHAN_W-1:0]        fade_amount,
    input  logic [rlsfs_pkg::SLOT_W-1:0]        slot_index,
    input  logic                                clearing,
    input  logic                                q_full,
    output logic                                push,
    output rlsfs_pkg::entry_t                   push_entry
);

    localparam int IDX_W  = rlsfs_pkg::IDX_W;
    localparam int SLOT_W = rlsfs_pkg::SLOT_W;
    localparam int ADDR_W = rlsfs_pkg::ADDR_W;
    // Reciprocal of the LED count: (x * MOD_RECIP) >> MOD_S is exact for any 16-bit x.
    localparam int MOD_S     = IDX_W + $clog2(LED_COUNT);
    localparam int MOD_RECIP = ((1 << MOD_S) + LED_COUNT - 1) / LED_COUNT;
    localparam int MPROD_W   = 2 * IDX_W + 1;
    localparam int DATA_END = rlsfs_pkg::LEAD_RESET_SLOTS
                              + LED_COUNT * rlsfs_pkg::BITS_PER_LED;
    localparam int PROD_W = 8 + 10;
    localparam int Q_W    = PROD_W - rlsfs_pkg::DIV3_SHIFT;

    rlsfs_pkg::front_state_t state_reg, state_next;

    logic                                  accept;
    rlsfs_pkg::cmd_t                       cmd_reg;
    logic [IDX_W-1:0]                      rem_reg;
    logic [IDX_W-1:0]                      rem_next;
    logic [IDX_W-1:0]                      quot_reg;
    logic [IDX_W-1:0]                      quot_next;
    logic [rlsfs_pkg::COLOR_W-1:0]         color_reg;
    logic [rlsfs_pkg::KEEP_W-1:0]          keep_reg;
    logic [SLOT_W-1:0]                     slot_reg;

    logic [MPROD_W-1:0]                    quot_full;
    logic                                  in_data;
    logic [SLOT_W-1:0]                     rel;
    logic [PROD_W-1:0]                     prod;
    logic [Q_W-1:0]                        led_q;
    logic [SLOT_W-1:0]                     pos_full;

    assign accept = start && !busy;

    // led_index modulo LED_COUNT in two steps: quotient by reciprocal, then the remainder.
    assign quot_full = MPROD_W'(rem_reg) * MPROD_W'(MOD_RECIP);
    assign quot_next = IDX_W'(quot_full >> MOD_S);
    assign rem_next  = rem_reg - (quot_reg * IDX_W'(LED_COUNT));

    // Slot decode: region test, then LED number and bit position by divide by 24.
    assign in_data  = (slot_reg >= SLOT_W'(rlsfs_pkg::LEAD_RESET_SLOTS))
                      && (32'(slot_reg) < 32'(DATA_END));
    assign rel      = slot_reg - SLOT_W'(rlsfs_pkg::LEAD_RESET_SLOTS);
    assign prod     = PROD_W'(rel[SLOT_W-1:3]) * PROD_W'(rlsfs_pkg::DIV3_RECIP);
    assign led_q    = prod[PROD_W-1:rlsfs_pkg::DIV3_SHIFT];
    assign pos_full = rel - ((SLOT_W'(led_q) << 4) + (SLOT_W'(led_q) << 3));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rlsfs_pkg::F_IDLE:
            begin
                if (accept)
                begin
                    state_next = (rlsfs_pkg::cmd_t'(cmd) == rlsfs_pkg::CMD_SET_ONE)
                                 ? rlsfs_pkg::F_DIV : rlsfs_pkg::F_PUSH;
                end
            end
            rlsfs_pkg::F_DIV:
            begin
                state_next = rlsfs_pkg::F_MOD;
            end
            rlsfs_pkg::F_MOD:
            begin
                state_next = rlsfs_pkg::F_PUSH;
            end
            rlsfs_pkg::F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = rlsfs_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = rlsfs_pkg::F_IDLE;
            end
        endcase
    end

    // Outputs: handshake and the classified item.
    always_comb
    begin
        busy               = (state_reg != rlsfs_pkg::F_IDLE) || clearing;
        push               = (state_reg == rlsfs_pkg::F_PUSH) && !q_full;
        push_entry.op      = cmd_reg;
        push_entry.color   = color_reg;
        push_entry.keep    = keep_reg;
        push_entry.in_data = in_data;
        push_entry.bit_pos = pos_full[rlsfs_pkg::POS_W-1:0];
        push_entry.addr    = '0;
        unique case (cmd_reg)
            rlsfs_pkg::CMD_SET_ONE: push_entry.addr = rem_reg[ADDR_W-1:0];
            rlsfs_pkg::CMD_READ:    push_entry.addr = in_data ? ADDR_W'(led_q) : '0;
            default:                push_entry.addr = '0;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rlsfs_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Item payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= rlsfs_pkg::cmd_t'(cmd);
            rem_reg   <= led_index;
            color_reg <= {green, red, blue};
            keep_reg  <= rlsfs_pkg::KEEP_W'(rlsfs_pkg::FADE_FULL)
                         - rlsfs_pkg::KEEP_W'(fade_amount);
            slot_reg  <= slot_index;
        end
        else if (state_reg == rlsfs_pkg::F_DIV)
        begin
            quot_reg <= quot_next;
        end
        else if (state_reg == rlsfs_pkg::F_MOD)
        begin
            rem_reg <= rem_next;
        end
    end

endmodule

>>> rtl/core/rlsfs_queue.sv
`timescale 1ns / 1ps

module rlsfs_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rlsfs_pkg::entry_t push_entry,
    input  logic              pop,
    output rlsfs_pkg::entry_t head,
    output logic              full,
    output logic              empty
);

    localparam int DEPTH = rlsfs_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rlsfs_pkg::entry_t entries [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

    // The front never pushes into a full queue and the back never pops an empty one.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue pushed while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue popped while empty");

endmodule

>>> rtl/core/rlsfs_back.sv
`timescale 1ns / 1ps

module rlsfs_back #(
    parameter int LED_COUNT = rlsfs_pkg::LED_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rlsfs_pkg::cfg_wr_t            cfg,
    input  rlsfs_pkg::entry_t             head,
    input  logic                          q_empty,
    output logic                          pop,
    output logic                          clearing,
    output logic                          done,
    output logic [rlsfs_pkg::CODE_W-1:0]  slot_code,
    output logic                          is_read
);

    localparam int LED_W   = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int CNT_W   = $clog2(LED_COUNT + 1);
    localparam int COLOR_W = rlsfs_pkg::COLOR_W;
    localparam int CHAN_W  = rlsfs_pkg::CHAN_W;
    localparam int CODE_W  = rlsfs_pkg::CODE_W;
    localparam int MUL_W   = CHAN_W + rlsfs_pkg::KEEP_W;

    rlsfs_pkg::back_state_t state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       cnt_prev;
    rlsfs_pkg::entry_t      cur_reg;

    logic [CODE_W-1:0]      duty_one_reg;
    logic [CODE_W-1:0]      duty_zero_reg;
    logic [CODE_W-1:0]      duty_reset_reg;

    logic [COLOR_W-1:0]     store_mem [LED_COUNT];
    logic [COLOR_W-1:0]     rd_data_reg;
    logic                   mem_we;
    logic [LED_W-1:0]       mem_waddr;
    logic [COLOR_W-1:0]     mem_wdata;
    logic                   mem_re;
    logic [LED_W-1:0]       mem_raddr;

    logic                   done_reg, done_next;
    logic                   is_read_reg, is_read_next;
    logic [CODE_W-1:0]      slot_code_reg, slot_code_next;

    logic [MUL_W-1:0]       prod_g, prod_r, prod_b;
    logic [COLOR_W-1:0]     faded;
    logic [rlsfs_pkg::POS_W-1:0] bit_sel;
    logic                   bit_val;

    assign cnt_prev = cnt_reg - CNT_W'(1);

    // Fade of the word read last cycle: each channel scaled by keep/256.
    assign prod_g = MUL_W'(rd_data_reg[3*CHAN_W-1:2*CHAN_W]) * MUL_W'(cur_reg.keep);
    assign prod_r = MUL_W'(rd_data_reg[2*CHAN_W-1:CHAN_W]) * MUL_W'(cur_reg.keep);
    assign prod_b = MUL_W'(rd_data_reg[CHAN_W-1:0]) * MUL_W'(cur_reg.keep);
    assign faded  = {prod_g[2*CHAN_W-1:CHAN_W], prod_r[2*CHAN_W-1:CHAN_W],
                     prod_b[2*CHAN_W-1:CHAN_W]};

    // Slot bit: position zero is the green MSB.
    assign bit_sel = rlsfs_pkg::POS_W'(rlsfs_pkg::TOP_BIT) - cur_reg.bit_pos;
    assign bit_val = rd_data_reg[bit_sel];

    // Next state and sweep counter.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            rlsfs_pkg::B_CLEAR:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(LED_COUNT - 1))
                begin
                    state_next = rlsfs_pkg::B_IDLE;
                end
            end
            rlsfs_pkg::B_IDLE:
            begin
                cnt_next = '0;
                if (!q_empty)
                begin
                    unique case (head.op)
                        rlsfs_pkg::CMD_SET_ONE: state_next = rlsfs_pkg::B_IDLE;
                        rlsfs_pkg::CMD_SET_ALL: state_next = rlsfs_pkg::B_SET;
                        rlsfs_pkg::CMD_FADE:    state_next = rlsfs_pkg::B_FADE;
                        rlsfs_pkg::CMD_READ:    state_next = rlsfs_pkg::B_READ;
                    endcase
                end
            end
            rlsfs_pkg::B_SET:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(LED_COUNT - 1))
                begin
                    state_next = rlsfs_pkg::B_IDLE;
                end
            end
            rlsfs_pkg::B_FADE:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(LED_COUNT))
                begin
                    state_next = rlsfs_pkg::B_IDLE;
                end
            end
            rlsfs_pkg::B_READ:
            begin
                state_next = rlsfs_pkg::B_IDLE;
            end
            default:
            begin
                state_next = rlsfs_pkg::B_IDLE;
            end
        endcase
    end

    // Outputs: memory port controls, queue pop and the next result.
    always_comb
    begin
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = cnt_reg[LED_W-1:0];
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = cnt_reg[LED_W-1:0];
        done_next      = 1'b0;
        is_read_next   = 1'b0;
        slot_code_next = '0;
        unique case (state_reg)
            rlsfs_pkg::B_CLEAR:
            begin
                mem_we = 1'b1;
            end
            rlsfs_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    unique case (head.op)
                        rlsfs_pkg::CMD_SET_ONE:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = head.addr[LED_W-1:0];
                            mem_wdata = head.color;
                            done_next = 1'b1;
                        end
                        rlsfs_pkg::CMD_SET_ALL,
                        rlsfs_pkg::CMD_FADE:
                        begin
                            done_next = 1'b1;
                        end
                        rlsfs_pkg::CMD_READ:
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = head.addr[LED_W-1:0];
                        end
                    endcase
                end
            end
            rlsfs_pkg::B_SET:
            begin
                mem_we    = 1'b1;
                mem_wdata = cur_reg.color;
            end
            rlsfs_pkg::B_FADE:
            begin
                mem_re    = (cnt_reg < CNT_W'(LED_COUNT));
                mem_we    = (cnt_reg != '0);
                mem_waddr = cnt_prev[LED_W-1:0];
                mem_wdata = faded;
            end
            rlsfs_pkg::B_READ:
            begin
                done_next    = 1'b1;
                is_read_next = 1'b1;
                if (!cur_reg.in_data)
                begin
                    slot_code_next = duty_reset_reg;
                end
                else
                begin
                    slot_code_next = bit_val ? duty_one_reg : duty_zero_reg;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Control registers, duty registers and the result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rlsfs_pkg::B_CLEAR;
            cnt_reg        <= '0;
            done_reg       <= 1'b0;
            duty_one_reg   <= '0;
            duty_zero_reg  <= '0;
            duty_reset_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            if (cfg.valid)
            begin
                unique case (rlsfs_pkg::reg_idx_t'(cfg.index))
                    rlsfs_pkg::REG_DUTY_ONE:   duty_one_reg   <= cfg.data;
                    rlsfs_pkg::REG_DUTY_ZERO:  duty_zero_reg  <= cfg.data;
                    rlsfs_pkg::REG_DUTY_RESET: duty_reset_reg <= cfg.data;
                    default:                   duty_one_reg   <= duty_one_reg;
                endcase
            end
        end
    end

    // Current item and result payload.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        is_read_reg   <= is_read_next;
        slot_code_reg <= slot_code_next;
    end

    // Color store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= store_mem[mem_raddr];
        end
    end

    assign clearing  = (state_reg == rlsfs_pkg::B_CLEAR);
    assign done      = done_reg;
    assign is_read   = is_read_reg;
    assign slot_code = slot_code_reg;

    // The fade sweep never reads the entry it is writing in the same cycle.
    a_fade_ports_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rlsfs_pkg::B_FADE) && mem_we && mem_re |-> mem_waddr != mem_raddr)
        else $error("fade read and write hit the same entry");

    // A read answer only comes out of the read state.
    a_read_from_read_state: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && is_read_reg |-> $past(state_reg == rlsfs_pkg::B_READ))
        else $error("read result without a read");

    // Results for the other commands carry a zero code.
    a_zero_code_non_read: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !is_read_reg |-> slot_code_reg == '0)
        else $error("non-read result with a nonzero code");

    // No item leaves the queue while the store is being cleared.
    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !pop && !done_next)
        else $error("item handled during the clearing pass");

endmodule

>>> rtl/core/rgb_led_slot_frame_store_top.sv
`timescale 1ns / 1ps
// With the back end idle each item passes the front registers and the queue; set one
// first takes the divide and modulo steps. Set one, set all and fade answer as they are
// popped; a slot read answers from the read state after its store read. The front takes
// a new item only once it has pushed the last one. Set all and fade hold the back end
// for a sweep of the store; busy stays high once the two-entry queue behind them is full.
// Reset: the store is cleared to black with busy high; duty codes reset to 0.
// The receiver cannot stall: each result is shown for one cycle with done high.

module rgb_led_slot_frame_store_top #(
    parameter int LED_COUNT = rlsfs_pkg::LED_COUNT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           cmd,
    input  logic [rlsfs_pkg::IDX_W-1:0]          led_index,
    input  logic [rlsfs_pkg::CHAN_W-1:0]         red,
    input  logic [rlsfs_pkg::CHAN_W-1:0]         green,
    input  logic [rlsfs_pkg::CHAN_W-1:0]         blue,
    input  logic [rlsfs_pkg::CHAN_W-1:0]         fade_amount,
    input  logic [rlsfs_pkg::SLOT_W-1:0]         slot_index,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rlsfs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rlsfs_pkg::CODE_W-1:0]         cfg_data,
    output logic                                 done,
    output logic [rlsfs_pkg::CODE_W-1:0]         slot_code,
    output logic                                 is_read
);

    rlsfs_pkg::entry_t  push_entry;
    rlsfs_pkg::entry_t  head;
    rlsfs_pkg::cfg_wr_t cfg;
    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_empty;
    logic               clearing;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid && cfg_ready;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // Front end: accepts and classifies items.
    rlsfs_front #(
        .LED_COUNT (LED_COUNT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .led_index   (led_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .fade_amount (fade_amount),
        .slot_index  (slot_index),
        .clearing    (clearing),
        .q_full      (q_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    // Short queue between front and back.
    rlsfs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (q_full),
        .empty      (q_empty)
    );

    // Back end: color store, sweeps and slot reads.
    rlsfs_back #(
        .LED_COUNT (LED_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .clearing  (clearing),
        .done      (done),
        .slot_code (slot_code),
        .is_read   (is_read)
    );

endmodule

>>> tb/sv/tb_rgb_led_slot_frame_store_top.sv
`timescale 1ns / 1ps

module tb_rgb_led_slot_frame_store_top;

    localparam int IDX_W            = rlsfs_pkg::IDX_W;
    localparam int CHAN_W           = rlsfs_pkg::CHAN_W;
    localparam int SLOT_W           = rlsfs_pkg::SLOT_W;
    localparam int CODE_W           = rlsfs_pkg::CODE_W;
    localparam int COLOR_W          = rlsfs_pkg::COLOR_W;
    localparam int CFG_IDX_W        = rlsfs_pkg::CFG_IDX_W;
    localparam int LEAD_RESET_SLOTS = rlsfs_pkg::LEAD_RESET_SLOTS;
    localparam int BITS_PER_LED     = rlsfs_pkg::BITS_PER_LED;
    localparam int FADE_FULL        = rlsfs_pkg::FADE_FULL;

    localparam int LEDS        = rlsfs_pkg::LED_COUNT_DEF;
    localparam int DATA_END    = LEAD_RESET_SLOTS + LEDS * BITS_PER_LED;
    localparam int LAST_SLOT   = (1 << SLOT_W) - 1;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 72;

    // One command item as it goes to the block.
    typedef struct {
        rlsfs_pkg::cmd_t   op;
        logic [IDX_W-1:0]  led;
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] amount;
        logic [SLOT_W-1:0] slot;
    } frame_cmd_t;

    // One result item as it comes back.
    typedef struct {
        logic [CODE_W-1:0] code;
        logic              is_read;
    } slot_result_t;

    // A row of the directed table, with an optional hand-typed result.
    typedef struct {
        frame_cmd_t        item;
        bit                typed;
        logic [CODE_W-1:0] code;
    } directed_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           cmd = rlsfs_pkg::CMD_SET_ONE;
    logic [IDX_W-1:0]     led_index = '0;
    logic [CHAN_W-1:0]    red = '0;
    logic [CHAN_W-1:0]    green = '0;
    logic [CHAN_W-1:0]    blue = '0;
    logic [CHAN_W-1:0]    fade_amount = '0;
    logic [SLOT_W-1:0]    slot_index = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = rlsfs_pkg::REG_DUTY_ONE;
    logic [CODE_W-1:0]    cfg_data = '0;
    logic                 done;
    logic [CODE_W-1:0]    slot_code;
    logic                 is_read;

    // Predictor state: the color store in GRB order and the three duty codes.
    logic [COLOR_W-1:0] led_colors [LEDS];
    logic [CODE_W-1:0]  code_one;
    logic [CODE_W-1:0]  code_zero;
    logic [CODE_W-1:0]  code_reset;

    slot_result_t  expected_codes [$];
    directed_row_t directed_rows [$];
    int            errors = 0;
    int            idle_pct = 0;
    int            stall_cycles = 0;
    int            results_seen = 0;
    int            cmd_counts [4] = '{0, 0, 0, 0};

    rgb_led_slot_frame_store_top #(
        .LED_COUNT(LEDS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .led_index(led_index),
        .red(red),
        .green(green),
        .blue(blue),
        .fade_amount(fade_amount),
        .slot_index(slot_index),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .done(done),
        .slot_code(slot_code),
        .is_read(is_read)
    );

    // Free-running clock.
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Apply one command to the predictor and work out the result it gives.
    task automatic frame_store_predict(input frame_cmd_t c, output slot_result_t res);
        int keep;
        int rel;
        int pos;
        logic [COLOR_W-1:0] w;
        begin
            res.code = '0;
            res.is_read = 1'b0;
            case (c.op)
                rlsfs_pkg::CMD_SET_ONE:
                begin
                    led_colors[c.led % LEDS] = {c.g, c.r, c.b};
                end
                rlsfs_pkg::CMD_SET_ALL:
                begin
                    for (int i = 0; i < LEDS; i++)
                        led_colors[i] = {c.g, c.r, c.b};
                end
                rlsfs_pkg::CMD_FADE:
                begin
                    keep = FADE_FULL - int'(c.amount);
                    for (int i = 0; i < LEDS; i++)
                    begin
                        w = led_colors[i];
                        led_colors[i] = {8'((int'(w[23:16]) * keep) >> 8),
                                         8'((int'(w[15:8]) * keep) >> 8),
                                         8'((int'(w[7:0]) * keep) >> 8)};
                    end
                end
                default:
                begin
                    res.is_read = 1'b1;
                    if (c.slot < LEAD_RESET_SLOTS || c.slot >= DATA_END)
                        res.code = code_reset;
                    else
                    begin
                        // Slot 0 of an LED is the green MSB, bit 23 of the word.
                        rel = int'(c.slot) - LEAD_RESET_SLOTS;
                        pos = rel % BITS_PER_LED;
                        w = led_colors[rel / BITS_PER_LED];
                        res.code = w[COLOR_W - 1 - pos] ? code_one : code_zero;
                    end
                end
            endcase
        end
    endtask

    // Write all three duty registers back to back and mirror them in the predictor.
    task automatic program_duty(input logic [CODE_W-1:0] one_val,
                                input logic [CODE_W-1:0] zero_val,
                                input logic [CODE_W-1:0] reset_val);
        rlsfs_pkg::reg_idx_t idx [3];
        logic [CODE_W-1:0]   val [3];
        begin
            idx[0] = rlsfs_pkg::REG_DUTY_ONE;
            idx[1] = rlsfs_pkg::REG_DUTY_ZERO;
            idx[2] = rlsfs_pkg::REG_DUTY_RESET;
            val[0] = one_val;
            val[1] = zero_val;
            val[2] = reset_val;
            for (int i = 0; i < 3; i++)
            begin
                cfg_index <= idx[i];
                cfg_data  <= val[i];
                cfg_valid <= 1'b1;
                do @(posedge clk); while (!cfg_ready);
                case (idx[i])
                    rlsfs_pkg::REG_DUTY_ONE:  code_one = val[i];
                    rlsfs_pkg::REG_DUTY_ZERO: code_zero = val[i];
                    default:                  code_reset = val[i];
                endcase
            end
            cfg_valid <= 1'b0;
        end
    endtask

    // Present one item and hold it until the block takes it; start stays high.
    task automatic issue_cmd(input frame_cmd_t c, output slot_result_t res);
        begin
            cmd         <= c.op;
            led_index   <= c.led;
            red         <= c.r;
            green       <= c.g;
            blue        <= c.b;
            fade_amount <= c.amount;
            slot_index  <= c.slot;
            start       <= 1'b1;
            do @(posedge clk); while (busy);
            cmd_counts[c.op]++;
            frame_store_predict(c, res);
        end
    endtask

    // Random gaps on the sender side at the current idle rate.
    task automatic sender_idle();
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    // Hold off until every expected result is back and the block is quiet.
    task automatic drain();
        begin
            do @(posedge clk); while (expected_codes.size() != 0 || busy);
        end
    endtask

    function automatic logic [CHAN_W-1:0] pick_chan();
        int k;
        begin
            k = $urandom_range(7);
            if (k == 0)
                return 8'h00;
            if (k == 1)
                return 8'hFF;
            return 8'($urandom_range(255));
        end
    endfunction

    // Random item: reads most often, bulk commands less often since they walk the store.
    function automatic frame_cmd_t random_cmd();
        frame_cmd_t c;
        int k;
        begin
            k = $urandom_range(99);
            if (k < 45)
                c.op = rlsfs_pkg::CMD_READ;
            else if (k < 75)
                c.op = rlsfs_pkg::CMD_SET_ONE;
            else if (k < 85)
                c.op = rlsfs_pkg::CMD_SET_ALL;
            else
                c.op = rlsfs_pkg::CMD_FADE;
            c.led = $urandom_range(1) ? 16'($urandom_range(65535))
                                      : 16'($urandom_range(LEDS - 1));
            c.r = pick_chan();
            c.g = pick_chan();
            c.b = pick_chan();
            c.amount = pick_chan();
            if (c.op != rlsfs_pkg::CMD_READ)
                c.slot = 11'($urandom_range(LAST_SLOT));
            else
            begin
                k = $urandom_range(9);
                if (k == 0)
                    c.slot = 11'($urandom_range(LEAD_RESET_SLOTS - 1));
                else if (k == 1)
                    c.slot = 11'($urandom_range(LAST_SLOT, DATA_END));
                else
                    c.slot = 11'($urandom_range(DATA_END - 1, LEAD_RESET_SLOTS));
            end
            return c;
        end
    endfunction

    task automatic add_row(input rlsfs_pkg::cmd_t op, input int led, input int r, input int g,
                           input int b, input int amount, input int slot, input bit typed,
                           input int code);
        directed_row_t row;
        begin
            row.item.op = op;
            row.item.led = 16'(led);
            row.item.r = 8'(r);
            row.item.g = 8'(g);
            row.item.b = 8'(b);
            row.item.amount = 8'(amount);
            row.item.slot = 11'(slot);
            row.typed = typed;
            row.code = 8'(code);
            directed_rows.push_back(row);
        end
    endtask

    // Directed table, run with duty one FF, duty zero 00, duty reset 55.
    task automatic build_directed();
        begin
            // Black store after reset: lead, data, trailing and past-frame slots.
            add_row(rlsfs_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 1, 'h55);
            add_row(rlsfs_pkg::CMD_READ, 0, 0, 0, 0, 0, LEAD_RESET_SLOTS, 1, 'h00);
            add_row(rlsfs_pkg::CMD_READ, 0, 0, 0, 0, 0, DATA_END - 1, 1, 'h00);
            add_row(rlsfs_pkg::CMD_READ, 0, 0, 0, 0, 0, DATA_END, 1, 'h55);
            add_row(rlsfs_pkg::CMD_READ, 0, 0, 0, 0, 0, LAST_SLOT, 1, 'h55);
            // Green only on LED 0: GRB order, MSB first.
            add_row(rlsfs_pkg::CMD_SET_ONE, 0, 'h00, 'hFF, 'h00, 0, 0, 1, 'h00);
            add_row(rlsfs_pkg::CMD_READ, 0, 0, 0, 0, 0, LEAD_RESET_SLOTS, 1, 'hFF);
            add_row(rlsfs_pkg::CMD_READ, 0, 0, 0, 0, 0, LEAD_RESET_SLOTS + 8, 1, 'h00);
            // Top index wraps to the last LED.
            add_row(rlsfs_pkg::CMD_SET_ONE, 'hFFFF, 'h80, 'h00, 'h01, 0, 0, 1, 'h00);
            add_row(rlsfs_pkg::CMD_READ, 0, 0, 0, 0, 0, DATA_END - 16, 1, 'hFF);
            add_row(rlsfs_pkg::CMD_READ, 0, 0, 0, 0, 0, DATA_END - 1, 1, 'hFF);
            add_row(rlsfs_pkg::CMD_READ, 0, 0, 0, 0, 0, DATA_END - 2, 1, 'h00);
            // Index equal to the LED count lands on LED 0.
            add_row(rlsfs_pkg::CMD_SET_ONE, LEDS, 'hFF, 'hFF, 'hFF, 0, 0, 1, 'h00);
            add_row(rlsfs_pkg::CMD_READ, 0, 0, 0, 0, 0, LEAD_RESET_SLOTS + 23, 1, 'hFF);
            // A fade of zero leaves the store as it was.
            add_row(rlsfs_pkg::CMD_FADE, 0, 0, 0, 0, 0, 0, 1, 'h00);
            add_row(rlsfs_pkg::CMD_READ, 0, 0, 0, 0, 0, LEAD_RESET_SLOTS + 23, 0, 0);
            // Set all, then the strongest fade.
            add_row(rlsfs_pkg::CMD_SET_ALL, 0, 'hAA, 'h55, 'hFF, 0, 0, 1, 'h00);
            add_row(rlsfs_pkg::CMD_READ, 0, 0, 0, 0, 0, LEAD_RESET_SLOTS + 8, 0, 0);
            add_row(rlsfs_pkg::CMD_FADE, 0, 0, 0, 0, 255, 0, 1, 'h00);
            add_row(rlsfs_pkg::CMD_READ, 0, 0, 0, 0, 0, LEAD_RESET_SLOTS + 8, 0, 0);
            // Half fade of full white.
            add_row(rlsfs_pkg::CMD_SET_ALL, 0, 'hFF, 'hFF, 'hFF, 0, 0, 1, 'h00);
            add_row(rlsfs_pkg::CMD_FADE, 0, 0, 0, 0, 128, 0, 1, 'h00);
            add_row(rlsfs_pkg::CMD_READ, 0, 0, 0, 0, 0, LEAD_RESET_SLOTS, 0, 0);
            add_row(rlsfs_pkg::CMD_READ, 0, 0, 0, 0, 0, LEAD_RESET_SLOTS + 1, 0, 0);
            add_row(rlsfs_pkg::CMD_SET_ONE, 'h1234, 'h12, 'h34, 'h56, 0, 0, 1, 'h00);
            add_row(rlsfs_pkg::CMD_READ, 0, 0, 0, 0, 0,
                    LEAD_RESET_SLOTS + 52 * BITS_PER_LED + 2, 0, 0);
        end
    endtask

    // Result checker: each strobe is matched against the oldest expectation.
    always @(posedge clk)
    begin
        slot_result_t exp_res;
        if (rst_n && done === 1'b1)
        begin
            results_seen++;
            if (expected_codes.size() == 0)
            begin
                $display("%0t: unexpected result, slot_code %02h is_read %b",
                         $time, slot_code, is_read);
                errors++;
            end
            else
            begin
                exp_res = expected_codes.pop_front();
                if (slot_code !== exp_res.code)
                begin
                    $display("%0t: slot_code mismatch, expected %02h actual %02h",
                             $time, exp_res.code, slot_code);
                    errors++;
                end
                if (is_read !== exp_res.is_read)
                begin
                    $display("%0t: is_read mismatch, expected %b actual %b",
                             $time, exp_res.is_read, is_read);
                    errors++;
                end
            end
        end
    end

    // Watchdog: too long with no item, register write or result taken.
    always @(posedge clk)
    begin
        if ((start && !busy) || (cfg_valid && cfg_ready) || done === 1'b1)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // Main sequence: reset, directed table, then random phases under changing duty codes.
    initial
    begin
        slot_result_t res;
        frame_cmd_t   c;
        for (int i = 0; i < LEDS; i++)
            led_colors[i] = '0;
        code_one = '0;
        code_zero = '0;
        code_reset = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        build_directed();
        program_duty(8'hFF, 8'h00, 8'h55);
        idle_pct = 19;
        foreach (directed_rows[i])
        begin
            sender_idle();
            issue_cmd(directed_rows[i].item, res);
            if (directed_rows[i].typed)
            begin
                res.code = directed_rows[i].code;
                res.is_read = (directed_rows[i].item.op == rlsfs_pkg::CMD_READ);
            end
            expected_codes.push_back(res);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            // Duty codes change only once the block has gone quiet.
            start <= 1'b0;
            drain();
            case (p)
                0: program_duty(8'h00, 8'hFF, 8'h00);
                2: program_duty(8'hFF, 8'h00, 8'hFF);
                default: program_duty(8'($urandom_range(255)), 8'($urandom_range(255)),
                                      8'($urandom_range(255)));
            endcase
            idle_pct = (p < 2) ? 19 : ((p < 4) ? 62 : 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                sender_idle();
                if ($urandom_range(59) == 0)
                begin
                    start <= 1'b0;
                    drain();
                end
                c = random_cmd();
                issue_cmd(c, res);
                expected_codes.push_back(res);
            end
        end

        start <= 1'b0;
        drain();
        repeat (16) @(posedge clk);

        $display("Covered %0d set one, %0d set all, %0d fade and %0d slot reads",
                 cmd_counts[rlsfs_pkg::CMD_SET_ONE], cmd_counts[rlsfs_pkg::CMD_SET_ALL],
                 cmd_counts[rlsfs_pkg::CMD_FADE], cmd_counts[rlsfs_pkg::CMD_READ]);
        $display("over %0d duty settings with sender gaps of 0 to 62 percent; %0d results checked",
                 PHASES + 1, results_seen);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
